@@ rtl/assert_macros.svh @@
// Assertion macros used by the RTL file that carries checks.
// Each macro expects a clock named clk and an active-low reset named arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/tlg_pkg.sv @@
// Shared types and constants of the toroidal life generation engine.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package tlg_pkg;

	localparam int CMD_W       = 2;
	localparam int COL_FIELD_W = 6;
	localparam int ROW_FIELD_W = 6;
	localparam int CFG_W       = 7;
	localparam int CFG_INDEX_W = 1;
	localparam int IN_DATA_W   = 16;
	localparam int OUT_DATA_W  = 8;

	localparam logic [CFG_INDEX_W-1:0] CFG_GRID_WIDTH  = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_GRID_HEIGHT = 1'd1;

	localparam logic [CFG_W-1:0] RESET_GRID_SIZE = 7'd64;

	localparam logic [3:0] BIRTH_COUNT = 4'd3;
	localparam logic [3:0] STAY_COUNT  = 4'd2;

	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE = 2'd0,
		CMD_READ  = 2'd1,
		CMD_STEP  = 2'd2,
		CMD_BAD   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_GEN,
		ST_RESP
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic clear_run;
		logic exec_cell;
		logic gen_start;
		logic gen_run;
		logic gen_finish;
		logic load_out;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		cmd_t cmd;
		logic clear_last;
		logic gen_last;
		logic out_free;
	} dp_status_t;

endpackage

@@ rtl/tlg_ctrl.sv @@
// Controller state machine of the life engine: clearing pass, item decode, sweep, result.
// Depends on tlg_pkg for the state, command and status types.
`timescale 1ns / 1ps

module tlg_ctrl
	import tlg_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  dp_status_t status,
	output ctrl_cmd_t  ctrl
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (status.clear_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (status.cmd == CMD_STEP) state_d = ST_GEN;
				else state_d = ST_RESP;
			end
			ST_GEN: begin
				if (status.gen_last) state_d = ST_RESP;
			end
			ST_RESP: begin
				if (status.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		ctrl     = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				ctrl.clear_run = 1'b1;
			end
			ST_IDLE: begin
				s_tready     = 1'b1;
				ctrl.capture = s_tvalid;
			end
			ST_EXEC: begin
				if (status.cmd == CMD_STEP) ctrl.gen_start = 1'b1;
				else ctrl.exec_cell = 1'b1;
			end
			ST_GEN: begin
				ctrl.gen_run    = 1'b1;
				ctrl.gen_finish = status.gen_last;
			end
			ST_RESP: begin
				ctrl.load_out = status.out_free;
			end
			default: ;
		endcase
	end

endmodule

@@ rtl/tlg_dp.sv @@
// Datapath of the life engine: config registers, two row-wide grid stores, the
// three-row window with one rule lane per column, and the result register. Uses tlg_pkg.
`timescale 1ns / 1ps

module tlg_dp
	import tlg_pkg::*;
#(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [IN_DATA_W-1:0]   s_tdata,
	input  logic [CMD_W-1:0]       s_tuser,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]       cfg_data,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_DATA_W-1:0]  m_tdata,
	output logic [CMD_W-1:0]       m_tuser,
	input  ctrl_cmd_t              ctrl,
	output dp_status_t             status
);

	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int ROW_W     = $clog2(MAX_HEIGHT);
	localparam int WSZ_W     = $clog2(MAX_WIDTH + 1);
	localparam int HSZ_W     = $clog2(MAX_HEIGHT + 1);
	localparam int STEP_W    = $clog2(MAX_HEIGHT + 4);
	localparam int READ_LAST = MAX_HEIGHT + 1;
	localparam int STEP_LAST = MAX_HEIGHT + 3;

	// Configuration registers and the clamped active size.
	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;
	logic [WSZ_W-1:0] act_w;
	logic [HSZ_W-1:0] act_h;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RESET_GRID_SIZE;
			height_q <= RESET_GRID_SIZE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_GRID_WIDTH:  width_q  <= cfg_data;
				CFG_GRID_HEIGHT: height_q <= cfg_data;
			endcase
		end
	end

	always_comb begin
		priority if (width_q == '0) act_w = WSZ_W'(1);
		else if (32'(width_q) > 32'(MAX_WIDTH)) act_w = WSZ_W'(MAX_WIDTH);
		else act_w = WSZ_W'(width_q);
		priority if (height_q == '0) act_h = HSZ_W'(1);
		else if (32'(height_q) > 32'(MAX_HEIGHT)) act_h = HSZ_W'(MAX_HEIGHT);
		else act_h = HSZ_W'(height_q);
	end

	// Captured item.
	cmd_t                   cmd_q;
	logic [COL_FIELD_W-1:0] col_q;
	logic [ROW_FIELD_W-1:0] row_q;
	logic                   alive_q;
	logic                   in_range;

	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			cmd_q   <= cmd_t'(s_tuser);
			col_q   <= s_tdata[COL_FIELD_W-1:0];
			row_q   <= s_tdata[COL_FIELD_W +: ROW_FIELD_W];
			alive_q <= s_tdata[COL_FIELD_W + ROW_FIELD_W];
		end
	end

	assign in_range = (32'(col_q) < 32'(act_w)) && (32'(row_q) < 32'(act_h));

	// Control counters and the current-store flag.
	logic [ROW_W-1:0]  clr_q;
	logic [STEP_W-1:0] step_q;
	logic              bank_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			step_q <= '0;
			bank_q <= 1'b0;
		end else begin
			if (ctrl.clear_run) clr_q <= clr_q + ROW_W'(1);
			if (ctrl.gen_start) step_q <= '0;
			else if (ctrl.gen_run) step_q <= step_q + STEP_W'(1);
			if (ctrl.gen_finish) bank_q <= ~bank_q;
		end
	end

	// Read address and the tag that follows each sweep read down the pipeline.
	// The sweep reads the last active row first, then rows 0 up to the last,
	// then row 0 again, then the inactive rows, which are copied unchanged.
	logic [31:0]      stepx;
	logic [31:0]      hx;
	logic             rd_en;
	logic [ROW_W-1:0] rd_row;
	logic             tag_valid;
	logic             tag_we;
	logic             tag_copy;
	logic [ROW_W-1:0] tag_row;

	assign stepx   = 32'(step_q);
	assign hx      = 32'(act_h);
	assign tag_row = ROW_W'(stepx - 32'd2);

	always_comb begin
		rd_en     = 1'b0;
		rd_row    = ROW_W'(row_q);
		tag_valid = 1'b0;
		tag_we    = 1'b0;
		tag_copy  = 1'b0;
		priority if (ctrl.exec_cell) begin
			rd_en = (cmd_q == CMD_READ);
		end else if (ctrl.gen_run && stepx <= 32'(READ_LAST)) begin
			rd_en     = 1'b1;
			tag_valid = 1'b1;
			priority if (stepx == 32'd0) begin
				rd_row = ROW_W'(hx - 32'd1);
			end else if (stepx <= hx) begin
				rd_row = ROW_W'(stepx - 32'd1);
				tag_we = (stepx >= 32'd2);
			end else if (stepx == hx + 32'd1) begin
				rd_row = '0;
				tag_we = 1'b1;
			end else begin
				rd_row   = ROW_W'(stepx - 32'd2);
				tag_we   = 1'b1;
				tag_copy = 1'b1;
			end
		end else begin
			rd_en = 1'b0;
		end
	end

	// Grid stores, one row of cells per word.
	logic [MAX_WIDTH-1:0] grid_a [MAX_HEIGHT];
	logic [MAX_WIDTH-1:0] grid_b [MAX_HEIGHT];
	logic [MAX_WIDTH-1:0] rd_a_q;
	logic [MAX_WIDTH-1:0] rd_b_q;
	logic [MAX_WIDTH-1:0] rd_data;
	logic                 we_a;
	logic                 we_b;
	logic [ROW_W-1:0]     wrow;
	logic [MAX_WIDTH-1:0] wmask;
	logic [MAX_WIDTH-1:0] wdata;

	always_ff @(posedge clk) begin
		if (we_a) begin
			for (int i = 0; i < MAX_WIDTH; i++) begin
				if (wmask[i]) grid_a[wrow][i] <= wdata[i];
			end
		end
		if (rd_en) rd_a_q <= grid_a[rd_row];
	end

	always_ff @(posedge clk) begin
		if (we_b) begin
			for (int i = 0; i < MAX_WIDTH; i++) begin
				if (wmask[i]) grid_b[wrow][i] <= wdata[i];
			end
		end
		if (rd_en) rd_b_q <= grid_b[rd_row];
	end

	assign rd_data = bank_q ? rd_b_q : rd_a_q;

	// Sweep pipeline: stage 1 holds the read row, stage 2 the window and the write.
	logic                 valid_s1;
	logic                 we_s1;
	logic                 copy_s1;
	logic [ROW_W-1:0]     row_s1;
	logic                 we_s2;
	logic                 copy_s2;
	logic [ROW_W-1:0]     row_s2;
	logic [MAX_WIDTH-1:0] top_q;
	logic [MAX_WIDTH-1:0] mid_q;
	logic [MAX_WIDTH-1:0] bot_q;
	logic [MAX_WIDTH-1:0] next_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			we_s1    <= 1'b0;
			we_s2    <= 1'b0;
		end else begin
			valid_s1 <= tag_valid;
			we_s1    <= tag_we;
			we_s2    <= valid_s1 && we_s1;
		end
	end

	always_ff @(posedge clk) begin
		copy_s1 <= tag_copy;
		row_s1  <= tag_row;
		copy_s2 <= copy_s1;
		row_s2  <= row_s1;
		if (valid_s1) begin
			top_q <= mid_q;
			mid_q <= bot_q;
			bot_q <= rd_data;
		end
	end

	// One rule lane per column; columns outside the active width keep their value.
	for (genvar c = 0; c < MAX_WIDTH; c++) begin : g_lane
		logic [COL_W-1:0] li;
		logic [COL_W-1:0] ri;
		logic [3:0]       n;

		assign li = (c == 0) ? COL_W'(act_w - WSZ_W'(1)) : COL_W'(c - 1);
		assign ri = (32'(c + 1) == 32'(act_w)) ? '0 : COL_W'(c + 1);
		assign n  = 4'(top_q[li]) + 4'(top_q[c]) + 4'(top_q[ri]) +
			4'(mid_q[li]) + 4'(mid_q[ri]) +
			4'(bot_q[li]) + 4'(bot_q[c]) + 4'(bot_q[ri]);
		assign next_row[c] = (32'(c) >= 32'(act_w)) ? mid_q[c] :
			((n == BIRTH_COUNT) || (mid_q[c] && (n == STAY_COUNT)));
	end

	// Single write port of the stores: clearing, cell writes and sweep writes never overlap.
	always_comb begin
		we_a  = 1'b0;
		we_b  = 1'b0;
		wrow  = ROW_W'(row_q);
		wmask = '0;
		wdata = '0;
		priority if (ctrl.clear_run) begin
			we_a  = 1'b1;
			we_b  = 1'b1;
			wrow  = clr_q;
			wmask = '1;
		end else if (ctrl.exec_cell && cmd_q == CMD_WRITE && in_range) begin
			we_a  = ~bank_q;
			we_b  = bank_q;
			wmask = MAX_WIDTH'(1) << COL_W'(col_q);
			wdata = {MAX_WIDTH{alive_q}};
		end else if (we_s2) begin
			we_a  = bank_q;
			we_b  = ~bank_q;
			wrow  = row_s2;
			wmask = '1;
			wdata = copy_s2 ? bot_q : next_row;
		end else begin
			we_a = 1'b0;
		end
	end

	// Result register.
	logic            out_valid_q;
	logic            res_q;
	logic            stat_q;
	logic [CMD_W-1:0] done_q;
	logic            res_d;
	logic            stat_d;

	always_comb begin
		unique case (cmd_q)
			CMD_WRITE: begin
				res_d  = in_range && alive_q;
				stat_d = ~in_range;
			end
			CMD_READ: begin
				res_d  = in_range && rd_data[COL_W'(col_q)];
				stat_d = ~in_range;
			end
			CMD_STEP: begin
				res_d  = 1'b0;
				stat_d = 1'b0;
			end
			CMD_BAD: begin
				res_d  = 1'b0;
				stat_d = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_out) begin
			res_q  <= res_d;
			stat_q <= stat_d;
			done_q <= cmd_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_DATA_W - 2){1'b0}}, stat_q, res_q};
	assign m_tuser  = done_q;

	assign status.cmd        = cmd_q;
	assign status.clear_last = (32'(clr_q) == 32'(MAX_HEIGHT - 1));
	assign status.gen_last   = (32'(step_q) == 32'(STEP_LAST));
	assign status.out_free   = ~out_valid_q || m_tready;

endmodule

@@ rtl/toroidal_life_generation_engine_top.sv @@
// A write, read or rejected item is taken in the idle state and decoded in the exec state;
// its result is loaded into the output register in the response state. A generation item
// first runs a sweep of the grid, one grid row per sweep cycle. No new item is taken until
// the result is loaded. A pending result waits in the output register meanwhile.
// Reset is asynchronous; afterwards a clearing pass empties both stores, during which
// no item is taken (configuration writes are).
`timescale 1ns / 1ps
`include "assert_macros.svh"

module toroidal_life_generation_engine_top
	import tlg_pkg::*;
#(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// s_tdata: col [5:0], row [11:6], alive [12], zero [15:13]
	input  logic [IN_DATA_W-1:0]   s_tdata,
	// s_tuser: command [1:0]
	input  logic [CMD_W-1:0]       s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// m_tdata: cell_res [0], status [1], zero [7:2]
	output logic [OUT_DATA_W-1:0]  m_tdata,
	// m_tuser: done_command [1:0]
	output logic [CMD_W-1:0]       m_tuser,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]       cfg_data
);

	ctrl_cmd_t  dp_cmd;
	dp_status_t dp_status;

	tlg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (dp_status),
		.ctrl     (dp_cmd)
	);

	tlg_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.ctrl      (dp_cmd),
		.status    (dp_status)
	);

	// The engine works on one item at a time.
	`ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "item taken while busy")
	// A result is never loaded over one that is still waiting.
	`ASSERT_SAME(a_no_overwrite, dp_cmd.load_out, !m_tvalid || m_tready, "result overwritten")
	// A taken result leaves the output unless a new one is loaded.
	`ASSERT_NEXT(a_out_drain, m_tvalid && m_tready && !dp_cmd.load_out, !m_tvalid,
		"result repeated")

endmodule

@@ test/testbench.sv @@
// Testbench for the toroidal life generation engine: directed and random items with
// a scoreboard that keeps its own copy of both grids. Depends on tlg_pkg and on
// toroidal_life_generation_engine_top.
`timescale 1ns / 1ps

module testbench;
	import tlg_pkg::*;

	localparam int GRID_COLS  = 64;
	localparam int GRID_ROWS  = 64;
	localparam int GRID_CELLS = GRID_COLS * GRID_ROWS;
	localparam int IDLE_LIMIT = 4000;
	localparam int REPORT_MAX = 10;
	localparam int PHASES     = 10;

	class life_scoreboard;
		typedef struct {
			bit   cell_val;
			bit   status;
			cmd_t cmd;
		} life_result_t;

		bit [GRID_CELLS-1:0] store [2];
		bit                  cur_sel;
		bit [CFG_W-1:0]      width_reg = RESET_GRID_SIZE;
		bit [CFG_W-1:0]      height_reg = RESET_GRID_SIZE;
		life_result_t        awaited [$];
		int                  errors;

		function int active_size(bit [CFG_W-1:0] raw, int limit);
			if (raw == 0)
				return 1;
			if (raw > limit)
				return limit;
			return int'(raw);
		endfunction

		function int active_cols();
			return active_size(width_reg, GRID_COLS);
		endfunction

		function int active_rows();
			return active_size(height_reg, GRID_ROWS);
		endfunction

		function void set_reg(logic [CFG_INDEX_W-1:0] idx, bit [CFG_W-1:0] val);
			if (idx == CFG_GRID_WIDTH)
				width_reg = val;
			else
				height_reg = val;
		endfunction

		function int live(int c, int r);
			return int'(store[cur_sel][c + r * GRID_COLS]);
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		// Cells outside the active window are carried over unchanged.
		function void next_generation();
			int w, h, n, rm, rp, cm, cp;
			bit [GRID_CELLS-1:0] nxt;
			w = active_cols();
			h = active_rows();
			nxt = store[cur_sel];
			for (int r = 0; r < h; r++) begin
				rm = (r + h - 1) % h;
				rp = (r + 1) % h;
				for (int c = 0; c < w; c++) begin
					cm = (c + w - 1) % w;
					cp = (c + 1) % w;
					n = live(cm, rm) + live(c, rm) + live(cp, rm) + live(cm, r)
						+ live(cp, r) + live(cm, rp) + live(c, rp) + live(cp, rp);
					nxt[c + r * GRID_COLS] = (n == BIRTH_COUNT)
						|| (n == STAY_COUNT && live(c, r) != 0);
				end
			end
			store[!cur_sel] = nxt;
			cur_sel = !cur_sel;
		endfunction

		function void note_item(cmd_t cmd, bit [5:0] col, bit [5:0] row, bit alive);
			life_result_t res;
			res.cell_val = 1'b0;
			res.status = 1'b0;
			res.cmd = cmd;
			case (cmd)
				CMD_STEP: next_generation();
				CMD_BAD: res.status = 1'b1;
				default: begin
					if (col >= active_cols() || row >= active_rows()) begin
						res.status = 1'b1;
					end else if (cmd == CMD_WRITE) begin
						store[cur_sel][col + row * GRID_COLS] = alive;
						res.cell_val = alive;
					end else begin
						res.cell_val = store[cur_sel][col + row * GRID_COLS];
					end
				end
			endcase
			awaited.push_back(res);
		endfunction

		function void check_result(logic got_cell, logic status, logic [CMD_W-1:0] cmd);
			life_result_t want;
			if (awaited.size() == 0) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("mismatch: result with none awaited: cell %b status %b command %0d",
						got_cell, status, cmd);
				return;
			end
			want = awaited.pop_front();
			if (got_cell !== want.cell_val || status !== want.status || cmd !== want.cmd) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("mismatch: cell %b/%b status %b/%b command %0d/%0d (expected/actual)",
						want.cell_val, got_cell, want.status, status, want.cmd, cmd);
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_DATA_W-1:0]   s_tdata;
	logic [CMD_W-1:0]       s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_DATA_W-1:0]  m_tdata;
	logic [CMD_W-1:0]       m_tuser;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_W-1:0]       cfg_data;

	life_scoreboard sb = new;
	int burst_left = 0;
	int idle_cycles = 0;

	toroidal_life_generation_engine_top #(
		.MAX_WIDTH (GRID_COLS),
		.MAX_HEIGHT(GRID_ROWS)
	) i_dut (.*);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		idle_cycles++;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				sb.note_item(cmd_t'(s_tuser), s_tdata[5:0], s_tdata[11:6], s_tdata[12]);
				idle_cycles = 0;
			end
			if (m_tvalid && m_tready) begin
				sb.check_result(m_tdata[0], m_tdata[1], m_tuser);
				idle_cycles = 0;
			end
		end
	end

	initial begin : watchdog
		while (idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		$display("tb: failure");
		$finish;
	end

	// The result side switches between free flow, light and heavy random stalls,
	// and a fixed pattern of long stalls.
	initial begin : receiver
		int mode, span;
		m_tready = 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(16, 96);
			for (int k = 0; k < span; k++) begin
				@(posedge clk);
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 3) != 0);
					2: m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= (k % 16 >= 12);
				endcase
			end
		end
	end

	// Returns with the accepting edge, or after a pause; valid stays high only when the
	// burst goes on, so the caller must send again or stop at once.
	task automatic send_item(cmd_t cmd, bit [5:0] col, bit [5:0] row, bit alive);
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {3'b000, alive, row, col};
		do
			@(posedge clk);
		while (!s_tready);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(0, 8);
		end
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, bit [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Most cell items land in a small cluster so that patterns form and evolve.
	task automatic run_phase(int count);
		int w, h, cx, cy, pick, pause_at;
		bit [5:0] col, row;
		cmd_t cmd;
		w = sb.active_cols();
		h = sb.active_rows();
		cx = $urandom_range(0, w - 1);
		cy = $urandom_range(0, h - 1);
		pause_at = $urandom_range(1, count - 1);
		for (int k = 0; k < count; k++) begin
			if (k == pause_at)
				drain_results();
			pick = $urandom_range(0, 99);
			cmd = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
			col = 6'((cx + $urandom_range(0, 4)) % w);
			row = 6'((cy + $urandom_range(0, 4)) % h);
			if (pick < 40) begin
				cmd = CMD_WRITE;
			end else if (pick < 60) begin
				cmd = CMD_READ;
			end else if (pick < 78) begin
				cmd = CMD_STEP;
			end else if (pick < 90) begin
				col = 6'($urandom);
				row = 6'($urandom);
			end else if (pick < 96) begin
				col = 6'(w - 1 + $urandom_range(0, 1));
				row = 6'(h - 1 + $urandom_range(0, 1));
			end else begin
				cmd = CMD_BAD;
				col = 6'($urandom);
				row = 6'($urandom);
			end
			send_item(cmd, col, row, $urandom_range(0, 9) < 7);
		end
	endtask

	initial begin : stimulus
		int cols_list [PHASES] = '{1, 2, 0, 3, 127, 7, 64, -1, 5, 64};
		int rows_list [PHASES] = '{1, 2, 3, 2, 5, 65, 64, -1, 5, 1};
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_WRITE;
		cfg_we = 1'b0;
		cfg_index = CFG_GRID_WIDTH;
		cfg_data = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Three corner cells make the opposite corner cell be born across both wraps.
		send_item(CMD_WRITE, 6'd0, 6'd0, 1'b1);
		send_item(CMD_WRITE, 6'd63, 6'd63, 1'b1);
		send_item(CMD_WRITE, 6'd63, 6'd0, 1'b1);
		send_item(CMD_READ, 6'd63, 6'd63, 1'b0);
		send_item(CMD_READ, 6'd1, 6'd1, 1'b1);
		send_item(CMD_WRITE, 6'd5, 6'd5, 1'b0);
		send_item(CMD_BAD, 6'd63, 6'd63, 1'b1);
		send_item(CMD_STEP, 6'd0, 6'd0, 1'b0);
		send_item(CMD_READ, 6'd0, 6'd63, 1'b0);
		send_item(CMD_READ, 6'd0, 6'd0, 1'b0);
		// A blinker flips between a row and a column.
		send_item(CMD_WRITE, 6'd10, 6'd20, 1'b1);
		send_item(CMD_WRITE, 6'd11, 6'd20, 1'b1);
		send_item(CMD_WRITE, 6'd12, 6'd20, 1'b1);
		send_item(CMD_STEP, 6'd63, 6'd63, 1'b1);
		send_item(CMD_READ, 6'd11, 6'd19, 1'b0);
		send_item(CMD_READ, 6'd10, 6'd20, 1'b0);
		send_item(CMD_STEP, 6'd0, 6'd0, 1'b0);
		send_item(CMD_READ, 6'd11, 6'd20, 1'b0);
		send_item(CMD_WRITE, 6'd42, 6'd21, 1'b1);
		send_item(CMD_READ, 6'd21, 6'd42, 1'b0);
		send_item(CMD_READ, 6'd42, 6'd21, 1'b0);
		drain_results();

		for (int p = 0; p < PHASES; p++) begin
			write_reg(CFG_GRID_WIDTH,
				CFG_W'(cols_list[p] < 0 ? $urandom_range(0, 127) : cols_list[p]));
			write_reg(CFG_GRID_HEIGHT,
				CFG_W'(rows_list[p] < 0 ? $urandom_range(0, 127) : rows_list[p]));
			run_phase(12);
			drain_results();
		end

		repeat (GRID_ROWS + 10) @(posedge clk);
		if (sb.pending() != 0) begin
			$display("mismatch: %0d results never arrived", sb.pending());
			sb.errors += sb.pending();
		end
		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
